@@ rtl/ssd_pkg.sv @@
// shared types, codes and segment table of the seven-segment display formatter
package ssd_pkg;

	localparam int DISPLAY_WORDS = 8;
	localparam int WORD_IDX_W    = 3;
	localparam int DEC_BITS      = 14;

	localparam logic [15:0] DEC_MAX   = 16'd9999;
	localparam logic [7:0]  BLANK_SEG = 8'h00;

	localparam logic [2:0] ACT_CLEAR   = 3'd0;
	localparam logic [2:0] ACT_DECIMAL = 3'd1;
	localparam logic [2:0] ACT_HEX     = 3'd2;
	localparam logic [2:0] ACT_ASCII   = 3'd3;
	localparam logic [2:0] ACT_MARKS   = 3'd4;
	localparam logic [2:0] ACT_FLUSH   = 3'd5;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] value;
		logic [7:0]  char_0;
		logic [7:0]  char_1;
		logic [7:0]  char_2;
		logic [7:0]  char_3;
		logic [2:0]  marks;
	} item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
		logic       last;
	} result_t;

	typedef struct packed {
		logic                  accept;
		logic                  conv_shift;
		logic                  conv_write;
		logic                  emit;
		logic                  emit_word;
		logic                  first;
		logic                  last;
		logic [WORD_IDX_W-1:0] word_idx;
	} cmd_t;

	function automatic logic [7:0] seg_of(input logic [3:0] code);
		logic [7:0] seg;
		case (code)
			4'h0: seg = 8'h3F;
			4'h1: seg = 8'h06;
			4'h2: seg = 8'h5B;
			4'h3: seg = 8'h4F;
			4'h4: seg = 8'h66;
			4'h5: seg = 8'h6D;
			4'h6: seg = 8'h7D;
			4'h7: seg = 8'h07;
			4'h8: seg = 8'h7F;
			4'h9: seg = 8'h6F;
			4'hA: seg = 8'h77;
			4'hB: seg = 8'h7C;
			4'hC: seg = 8'h39;
			4'hD: seg = 8'h5E;
			4'hE: seg = 8'h79;
			default: seg = 8'h71;
		endcase
		return seg;
	endfunction

endpackage

@@ rtl/seven_segment_display_formatter.sv @@
// top level of the seven-segment display formatter
//
// usage
// - an item is taken at a rising edge with start high and busy low; it carries
//   an action and its operands (value, four characters, marks)
// - clear, hex, ascii and marks update the display store at that edge; busy
//   stays low, so the next item may follow in the next cycle
// - decimal saturates to 9999 and runs a shift-and-add-three converter, one
//   bit per cycle over 14 bits, then a digit write; busy through both
// - flush sends 1 + 2*DISPLAY_WORDS bytes (17 by default): the address byte,
//   then low and high byte of each store word; busy while the controller
//   counts them out, one byte a cycle set by the byte counter in the controller
// - the first byte passes the state register, then the output byte and strobe
//   registers, and is flagged by first; last marks the final byte; the next
//   flush item can be taken once the controller has left the flush state
//   after emitting its last byte
// - each byte is on result for exactly one cycle while strobe is high; the
//   receiver cannot stall, so it must take every strobed byte
// - actions six and seven are taken and ignored
// - reset clears the store to all zero and returns the controller to idle
module seven_segment_display_formatter #(
	parameter int DISPLAY_WORDS = ssd_pkg::DISPLAY_WORDS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ssd_pkg::item_t   item,
	output logic             busy,
	output logic             strobe,
	output ssd_pkg::result_t result
);

	// command bundle from the controller to the datapath
	ssd_pkg::cmd_t cmd;

	// sequencing: idle, conversion steps, digit write, flush bytes
	ssd_ctrl #(
		.DisplayWords(DISPLAY_WORDS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(item.action),
		.busy  (busy),
		.strobe(strobe),
		.cmd   (cmd)
	);

	// store, segment mapping, bcd converter and output byte register
	ssd_datapath #(
		.DisplayWords(DISPLAY_WORDS)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item),
		.cmd   (cmd),
		.result(result)
	);

`ifndef SYNTHESIS
	// a flush keeps the block busy right after it is taken
	a_flush_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == ssd_pkg::ACT_FLUSH) |=> busy)
		else $error("flush taken but block not busy");

	// the opening address byte, flagged by first, follows a flush that is taken
	a_flush_first: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.action == ssd_pkg::ACT_FLUSH) |-> ##2 (strobe && result.first))
		else $error("flush did not open with the address byte");

	// bytes of one transfer come without gaps until the last
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |=> strobe)
		else $error("gap inside a flush transfer");

	// a transfer ends with a quiet cycle after the last byte
	a_end_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.last) |=> !strobe)
		else $error("byte strobed right after the last byte");

	// bytes before the last only appear while the flush is still running
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !result.last) |-> busy)
		else $error("flush byte strobed while idle");
`endif

endmodule

@@ rtl/ssd_datapath.sv @@
// display store, decimal converter and output byte register
module ssd_datapath #(
	parameter int DisplayWords = ssd_pkg::DISPLAY_WORDS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ssd_pkg::item_t  item,
	input  ssd_pkg::cmd_t   cmd,
	output ssd_pkg::result_t result
);

	localparam int IdxW = $clog2(DisplayWords);

	logic [7:0]                      words_q [DisplayWords];
	logic [ssd_pkg::DEC_BITS-1:0]    bin_q;
	logic [15:0]                     bcd_q;
	logic [15:0]                     bcd_adj;
	logic [15:0]                     sat_value;
	logic [3:0]                      dig [4];
	logic                            blank0;
	logic                            put_en;
	logic                            mark_en;
	logic                            clear_en;
	logic [7:0]                      mark_word;
	ssd_pkg::result_t                result_q;

	assign sat_value = (item.value > ssd_pkg::DEC_MAX) ? ssd_pkg::DEC_MAX : item.value;

	// add three to every bcd digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                               : bcd_q[4*i +: 4];
		end
	end

	assign mark_word = {4'b0000, item.marks[0], item.marks[1], item.marks[2], 1'b0};

	always_comb begin
		dig[0]   = bcd_q[15:12];
		dig[1]   = bcd_q[11:8];
		dig[2]   = bcd_q[7:4];
		dig[3]   = bcd_q[3:0];
		blank0   = 1'b0;
		put_en   = 1'b0;
		mark_en  = 1'b0;
		clear_en = 1'b0;
		if (cmd.conv_write) begin
			put_en = 1'b1;
		end else if (cmd.accept) begin
			unique case (item.action)
				ssd_pkg::ACT_CLEAR: begin
					clear_en = 1'b1;
				end
				ssd_pkg::ACT_HEX: begin
					put_en = 1'b1;
					dig[0] = item.value[15:12];
					dig[1] = item.value[11:8];
					dig[2] = item.value[7:4];
					dig[3] = item.value[3:0];
				end
				ssd_pkg::ACT_ASCII: begin
					put_en = 1'b1;
					dig[0] = item.char_0[3:0];
					dig[1] = item.char_1[3:0];
					dig[2] = item.char_2[3:0];
					dig[3] = item.char_3[3:0];
					// midnight correction, else blank a leading zero
					if (item.char_0[3:0] == 4'd0 && item.char_1[3:0] == 4'd0) begin
						dig[0] = 4'd1;
						dig[1] = 4'd2;
					end else if (item.char_0[3:0] == 4'd0) begin
						blank0 = 1'b1;
					end
				end
				ssd_pkg::ACT_MARKS: begin
					mark_en = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DisplayWords; i++) begin
				words_q[i] <= 8'h00;
			end
		end else if (clear_en) begin
			for (int i = 0; i < DisplayWords; i++) begin
				words_q[i] <= 8'h00;
			end
		end else begin
			if (put_en) begin
				words_q[0] <= blank0 ? ssd_pkg::BLANK_SEG : ssd_pkg::seg_of(dig[0]);
				words_q[1] <= ssd_pkg::seg_of(dig[1]);
				words_q[3] <= ssd_pkg::seg_of(dig[2]);
				words_q[4] <= ssd_pkg::seg_of(dig[3]);
			end
			if (mark_en) begin
				words_q[2] <= mark_word;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && item.action == ssd_pkg::ACT_DECIMAL) begin
			bin_q <= sat_value[ssd_pkg::DEC_BITS-1:0];
			bcd_q <= 16'h0000;
		end else if (cmd.conv_shift) begin
			bcd_q <= {bcd_adj[14:0], bin_q[ssd_pkg::DEC_BITS-1]};
			bin_q <= {bin_q[ssd_pkg::DEC_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result_q.data_byte <= cmd.emit_word ? words_q[cmd.word_idx[IdxW-1:0]] : 8'h00;
			result_q.first     <= cmd.first;
			result_q.last      <= cmd.last;
		end
	end

	assign result = result_q;

endmodule

@@ rtl/ssd_ctrl.sv @@
// controller state machine: decimal conversion sequencing and flush byte count
module ssd_ctrl #(
	parameter int DisplayWords = ssd_pkg::DISPLAY_WORDS
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [2:0]    action,
	output logic          busy,
	output logic          strobe,
	output ssd_pkg::cmd_t cmd
);

	localparam int LastIdx = 2 * DisplayWords;
	localparam int CntMax  = (LastIdx > ssd_pkg::DEC_BITS - 1) ? LastIdx
	                                                           : ssd_pkg::DEC_BITS - 1;
	localparam int CntW    = $clog2(CntMax + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_WRITE,
		ST_FLUSH
	} state_t;

	state_t          state_q;
	logic [CntW-1:0] cnt_q;
	logic            strobe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_FLUSH);
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						unique case (action)
							ssd_pkg::ACT_DECIMAL: state_q <= ST_CONVERT;
							ssd_pkg::ACT_FLUSH:   state_q <= ST_FLUSH;
							default:              state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CONVERT: begin
					if (cnt_q == CntW'(ssd_pkg::DEC_BITS - 1)) begin
						state_q <= ST_WRITE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					if (cnt_q == CntW'(LastIdx)) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;

	// odd byte numbers carry a store word, even ones the address or a zero high byte
	always_comb begin
		cmd            = '0;
		cmd.accept     = start && (state_q == ST_IDLE);
		cmd.conv_shift = (state_q == ST_CONVERT);
		cmd.conv_write = (state_q == ST_WRITE);
		cmd.emit       = (state_q == ST_FLUSH);
		cmd.emit_word  = cnt_q[0];
		cmd.first      = (state_q == ST_FLUSH) && (cnt_q == '0);
		cmd.last       = (state_q == ST_FLUSH) && (cnt_q == CntW'(LastIdx));
		cmd.word_idx   = ssd_pkg::WORD_IDX_W'(cnt_q >> 1);
	end

endmodule

@@ verif/tb_seven_segment_display_formatter.sv @@
// testbench for the seven-segment display formatter, checked against a shadow store
module tb_seven_segment_display_formatter;
	timeunit 1ns;
	timeprecision 1ps;

	// spare action codes, taken by the block and ignored
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;

	// blank marker for a digit position, outside the 0..F range
	localparam logic [4:0] DIGIT_BLANK = 5'h10;

	// quiet cycles after the last byte, longer than the decimal conversion
	localparam int SETTLE_CYCLES = 24;
	// generous run limit, well above the slowest correct run
	localparam int CYCLE_LIMIT   = 200000;
	localparam int REPORT_LIMIT  = 10;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             start;
	ssd_pkg::item_t   item;
	logic             busy;
	logic             strobe;
	ssd_pkg::result_t result;

	// shadow of the display store, updated when an item is accepted
	logic [7:0]       shadow_words [ssd_pkg::DISPLAY_WORDS];
	// bytes a flush is expected to put on the result port, oldest first
	ssd_pkg::result_t expected_bytes[$];

	// segment patterns for hex digits 0..F
	logic [7:0] seg_lut [16] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
		8'h7F, 8'h6F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71
	};

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	int unsigned sender_idle_pct = 0;

	seven_segment_display_formatter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	always #5 clk = ~clk;

	// run limit, catches a hang in the controller or a lost byte
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s", $realtime, msg);
	endtask

	// write four digit codes into the digit words, left to right
	task automatic place_digits(input logic [4:0] d0, input logic [4:0] d1,
	                            input logic [4:0] d2, input logic [4:0] d3);
		logic [4:0] dig [4];
		int         slot [4];
		dig  = '{d0, d1, d2, d3};
		slot = '{0, 1, 3, 4};
		for (int i = 0; i < 4; i++)
			shadow_words[slot[i]] = dig[i][4] ? 8'h00 : seg_lut[dig[i][3:0]];
	endtask

	// apply one accepted item to the shadow store and queue any flush bytes
	task automatic update_display(input ssd_pkg::item_t it);
		int unsigned      num;
		logic [3:0]       n0, n1;
		ssd_pkg::result_t r;
		case (it.action)
			ssd_pkg::ACT_CLEAR: begin
				for (int i = 0; i < ssd_pkg::DISPLAY_WORDS; i++)
					shadow_words[i] = 8'h00;
			end
			ssd_pkg::ACT_DECIMAL: begin
				num = it.value;
				if (num > 9999)
					num = 9999;
				place_digits(5'(num / 1000), 5'((num / 100) % 10),
				             5'((num / 10) % 10), 5'(num % 10));
			end
			ssd_pkg::ACT_HEX: begin
				place_digits({1'b0, it.value[15:12]}, {1'b0, it.value[11:8]},
				             {1'b0, it.value[7:4]}, {1'b0, it.value[3:0]});
			end
			ssd_pkg::ACT_ASCII: begin
				n0 = it.char_0[3:0];
				n1 = it.char_1[3:0];
				// midnight correction: a leading 00 shows as 12
				if (n0 == 4'h0 && n1 == 4'h0)
					place_digits(5'd1, 5'd2, {1'b0, it.char_2[3:0]},
					             {1'b0, it.char_3[3:0]});
				// a lone leading zero is blanked
				else if (n0 == 4'h0)
					place_digits(DIGIT_BLANK, {1'b0, n1}, {1'b0, it.char_2[3:0]},
					             {1'b0, it.char_3[3:0]});
				else
					place_digits({1'b0, n0}, {1'b0, n1}, {1'b0, it.char_2[3:0]},
					             {1'b0, it.char_3[3:0]});
			end
			ssd_pkg::ACT_MARKS: begin
				// colon in bit 1, upper dot in bit 2, lower dot in bit 3
				shadow_words[2] = {4'h0, it.marks[0], it.marks[1], it.marks[2], 1'b0};
			end
			ssd_pkg::ACT_FLUSH: begin
				// address byte, then low and high byte of every word
				r = '{data_byte: 8'h00, first: 1'b1, last: 1'b0};
				expected_bytes.push_back(r);
				for (int i = 0; i < ssd_pkg::DISPLAY_WORDS; i++) begin
					r = '{data_byte: shadow_words[i], first: 1'b0, last: 1'b0};
					expected_bytes.push_back(r);
					r = '{data_byte: 8'h00, first: 1'b0,
					      last: (i == ssd_pkg::DISPLAY_WORDS - 1)};
					expected_bytes.push_back(r);
				end
			end
			default: begin
				// spare actions leave the store alone
			end
		endcase
	endtask

	// present one item and hold it until the block takes it
	task automatic send_item(input ssd_pkg::item_t it);
		// idle one cycle at a time, each with the sender's idle chance
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		// busy is sampled at the edge, so this sees its value before the edge
		@(posedge clk);
		while (busy)
			@(posedge clk);
		update_display(it);
		@(negedge clk);
	endtask

	// wait for every queued byte, then SETTLE_CYCLES quiet cycles to catch stray strobes
	task automatic drain_bytes();
		start <= 1'b0;
		while (expected_bytes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic ssd_pkg::item_t make_item(input logic [2:0] act,
	                                             input logic [15:0] val,
	                                             input logic [31:0] chars,
	                                             input logic [2:0] mk);
		ssd_pkg::item_t it;
		it.action = act;
		it.value  = val;
		it.char_0 = chars[31:24];
		it.char_1 = chars[23:16];
		it.char_2 = chars[15:8];
		it.char_3 = chars[7:0];
		it.marks  = mk;
		return it;
	endfunction

	function automatic ssd_pkg::item_t flush_item();
		ssd_pkg::item_t it;
		it = make_item(ssd_pkg::ACT_FLUSH, 16'($urandom), $urandom, 3'($urandom));
		return it;
	endfunction

	// check each strobed byte against the oldest expected one
	always @(posedge clk) begin
		ssd_pkg::result_t want;
		if (arst_n && strobe) begin
			if (expected_bytes.size() == 0) begin
				note_mismatch($sformatf("unexpected byte %02h first %0b last %0b",
				              result.data_byte, result.first, result.last));
			end else begin
				want = expected_bytes.pop_front();
				if (result.data_byte !== want.data_byte || result.first !== want.first ||
				    result.last !== want.last)
					note_mismatch($sformatf(
						"expected %02h first %0b last %0b, got %02h first %0b last %0b",
						want.data_byte, want.first, want.last,
						result.data_byte, result.first, result.last));
			end
		end
	end

	// store is all zero after reset
	task automatic test_reset_contents();
		send_item(flush_item());
		drain_bytes();
	endtask

	// decimal digits, with saturation above 9999
	task automatic test_decimal();
		logic [15:0] vals [4];
		vals = '{16'd1234, 16'd10000, 16'hFFFF, 16'd0};
		foreach (vals[i]) begin
			send_item(make_item(ssd_pkg::ACT_DECIMAL, vals[i], 32'h0, 3'd0));
			send_item(flush_item());
		end
		drain_bytes();
	endtask

	// hex nibbles, most significant first
	task automatic test_hex();
		send_item(make_item(ssd_pkg::ACT_HEX, 16'hFFFF, 32'hFFFF_FFFF, 3'd7));
		send_item(flush_item());
		send_item(make_item(ssd_pkg::ACT_HEX, 16'hA5C3, 32'h0, 3'd0));
		send_item(flush_item());
		drain_bytes();
	endtask

	// midnight correction, blanked leading zero, plain characters
	task automatic test_ascii();
		send_item(make_item(ssd_pkg::ACT_ASCII, 16'h0, 32'h0000_0000, 3'd0));
		send_item(flush_item());
		send_item(make_item(ssd_pkg::ACT_ASCII, 16'h0, 32'h3039_3537, 3'd0));
		send_item(flush_item());
		send_item(make_item(ssd_pkg::ACT_ASCII, 16'hFFFF, 32'hFFFF_FFFF, 3'd7));
		send_item(flush_item());
		drain_bytes();
	endtask

	// colon and dots into the middle word
	task automatic test_marks();
		send_item(make_item(ssd_pkg::ACT_MARKS, 16'h0, 32'h0, 3'd7));
		send_item(flush_item());
		send_item(make_item(ssd_pkg::ACT_MARKS, 16'h0, 32'h0, 3'd5));
		send_item(flush_item());
		drain_bytes();
	endtask

	// spare actions change nothing, clear zeroes the store
	task automatic test_spare_and_clear();
		send_item(make_item(ACT_SPARE_6, 16'hFFFF, 32'hFFFF_FFFF, 3'd7));
		send_item(make_item(ACT_SPARE_7, 16'h0, 32'h0000_0000, 3'd0));
		send_item(flush_item());
		send_item(make_item(ssd_pkg::ACT_CLEAR, 16'h1234, 32'h3132_3334, 3'd2));
		send_item(flush_item());
		drain_bytes();
	endtask

	// mostly updates followed by flushes, random content, a few spare codes
	function automatic ssd_pkg::item_t random_item();
		ssd_pkg::item_t it;
		int unsigned    pick;
		it = make_item(3'($urandom), 16'($urandom), $urandom, 3'($urandom));
		pick = $urandom_range(99);
		if (pick < 30)
			it.action = ssd_pkg::ACT_FLUSH;
		else if (pick < 46)
			it.action = ssd_pkg::ACT_DECIMAL;
		else if (pick < 60)
			it.action = ssd_pkg::ACT_HEX;
		else if (pick < 76)
			it.action = ssd_pkg::ACT_ASCII;
		else if (pick < 89)
			it.action = ssd_pkg::ACT_MARKS;
		else if (pick < 95)
			it.action = ssd_pkg::ACT_CLEAR;
		else
			it.action = $urandom_range(1) ? ACT_SPARE_6 : ACT_SPARE_7;
		// keep half the decimals in range so all digit values show
		if (it.action == ssd_pkg::ACT_DECIMAL && $urandom_range(1))
			it.value = 16'($urandom_range(9999));
		// clock-style digit strings most of the time, zero pairs now and then
		if (it.action == ssd_pkg::ACT_ASCII && $urandom_range(3) != 0) begin
			it.char_0 = 8'($urandom_range(8'h30, 8'h39));
			it.char_1 = 8'($urandom_range(8'h30, 8'h39));
			it.char_2 = 8'($urandom_range(8'h30, 8'h39));
			it.char_3 = 8'($urandom_range(8'h30, 8'h39));
			if ($urandom_range(3) == 0)
				it.char_0 = 8'h30;
		end
		return it;
	endfunction

	task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct);
		sender_idle_pct = idle_pct;
		for (int unsigned k = 0; k < n_items; k++)
			send_item(random_item());
		drain_bytes();
	endtask

	initial begin
		arst_n <= 1'b0;
		start  <= 1'b0;
		item   <= '0;
		for (int i = 0; i < ssd_pkg::DISPLAY_WORDS; i++)
			shadow_words[i] = 8'h00;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_contents();
		test_decimal();
		test_hex();
		test_ascii();
		test_marks();
		test_spare_and_clear();

		// sender rarely idle, then often idle, then never idle
		test_random_traffic(150, 8);
		test_random_traffic(150, 55);
		test_random_traffic(142, 0);

		if (mismatch_count == 0 && expected_bytes.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
